FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

FILE: sv/mwd_pkg.sv
package mwd_pkg;

  localparam int MAX_DIFF_LEN = 8192;
  localparam int MAX_AVG_LEN  = 1024;
  localparam int HIST_AW      = $clog2(MAX_DIFF_LEN);
  localparam int AVG_AW       = $clog2(MAX_AVG_LEN);
  localparam int DIFF_LEN_W   = 14;
  localparam int AVG_LEN_W    = 11;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int ACC_W    = 48;
  localparam int COEF_W   = 32;
  localparam int SUM_W    = 34;
  localparam int RES_W    = 24;
  localparam int DEC_W    = 32;
  localparam int SAT_IN_W = 35;

  // register map
  localparam logic [1:0] REG_DECAY     = 2'd0;
  localparam logic [1:0] REG_DIFF_LEN  = 2'd1;
  localparam logic [1:0] REG_AVG_LEN   = 2'd2;
  localparam logic [1:0] REG_AVG_RECIP = 2'd3;

  localparam logic [COEF_W-1:0]     DECAY_RST     = 32'd208013;
  localparam logic [DIFF_LEN_W-1:0] DIFF_LEN_RST  = 14'd8000;
  localparam logic [AVG_LEN_W-1:0]  AVG_LEN_RST   = 11'd1000;
  localparam logic [COEF_W-1:0]     AVG_RECIP_RST = 32'd4294967;

  localparam logic signed [SAT_IN_W-1:0] SAT_HI = 35'sd8388607;
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = -35'sd8388608;

  typedef logic signed [RES_W-1:0] res_t;

  function automatic res_t sat_res(input logic signed [SAT_IN_W-1:0] v);
    res_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[RES_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[RES_W-1:0];
    end else begin
      r = v[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/mwd_ram.sv
// Simple dual-port RAM, registered read.
module mwd_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/moving_window_deconvolution_filter_top.sv
// Moving-window deconvolution: one 16-bit sample in, one result word out.
// m_tvalid is set on leaving ST_OUT, after ST_ACC, ST_DIFF, ST_SUM and ST_MULR;
// ST_OUT holds while the output word waits. No new word is taken until the walk
// ends: read/modify/write of both history RAMs and split reciprocal multiply.
// Reset (rst, sync): clears pointers, accumulator, window sum and output valid,
// loads register defaults; history RAMs read as zero until written (wrap flags).
module moving_window_deconvolution_filter_top
  import mwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // [31:0] deconvolved, [55:32] differenced, [79:56] averaged
);

  `include "assert_macros.svh"

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a sample, launch RAM reads
  localparam logic [2:0] ST_ACC  = 3'd1;  // update deconvolution accumulator
  localparam logic [2:0] ST_DIFF = 3'd2;  // window difference, write acc history
  localparam logic [2:0] ST_SUM  = 3'd3;  // running sum, write diff history
  localparam logic [2:0] ST_MULR = 3'd4;  // sum times reciprocal, two halves
  localparam logic [2:0] ST_OUT  = 3'd5;  // combine, saturate, load output reg

  // config registers
  logic [COEF_W-1:0]     decay_coef;
  logic [DIFF_LEN_W-1:0] diff_len;
  logic [AVG_LEN_W-1:0]  avg_len;
  logic [COEF_W-1:0]     avg_recip;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_coef <= DECAY_RST;
      diff_len   <= DIFF_LEN_RST;
      avg_len    <= AVG_LEN_RST;
      avg_recip  <= AVG_RECIP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DECAY:     decay_coef <= cfg_data[COEF_W-1:0];
        REG_DIFF_LEN:  diff_len   <= cfg_data[DIFF_LEN_W-1:0];
        REG_AVG_LEN:   avg_len    <= cfg_data[AVG_LEN_W-1:0];
        REG_AVG_RECIP: avg_recip  <= cfg_data[COEF_W-1:0];
      endcase
    end
  end

  logic [2:0] state;
  logic [2:0] state_next;

  logic                       accept;
  logic                       out_free;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] prev;
  logic signed [48:0]         prod;        // c * prev, Q16 with 32 frac bits
  logic [ACC_W-1:0]           acc;
  logic [ACC_W-1:0]           acc_next;
  logic [HIST_AW-1:0]         hp;
  logic                       hp_wrapped;
  logic [AVG_AW-1:0]          ap;
  logic                       ap_wrapped;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_next;
  res_t                       diff_q;
  logic signed [50:0]         p_lo;
  logic signed [50:0]         p_hi;

  // window lengths clamped to [1, max]; the max maps to a zero offset
  logic [DIFF_LEN_W-1:0] m_eff;
  logic [AVG_LEN_W-1:0]  l_eff;
  logic [HIST_AW-1:0]    acc_rd_addr;
  logic [AVG_AW-1:0]     dif_rd_addr;
  logic                  acc_old_ok;
  logic                  dif_old_ok;
  logic [ACC_W-1:0]      acc_rd_data;
  logic [RES_W-1:0]      dif_rd_data;

  always_comb begin
    priority if (diff_len == '0) begin
      m_eff = DIFF_LEN_W'(1);
    end else if (diff_len > DIFF_LEN_W'(MAX_DIFF_LEN)) begin
      m_eff = DIFF_LEN_W'(MAX_DIFF_LEN);
    end else begin
      m_eff = diff_len;
    end
    priority if (avg_len == '0) begin
      l_eff = AVG_LEN_W'(1);
    end else if (avg_len > AVG_LEN_W'(MAX_AVG_LEN)) begin
      l_eff = AVG_LEN_W'(MAX_AVG_LEN);
    end else begin
      l_eff = avg_len;
    end
  end

  assign acc_rd_addr = hp - m_eff[HIST_AW-1:0];
  assign dif_rd_addr = ap - l_eff[AVG_AW-1:0];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // history RAMs: entries below the write pointer are written; all once wrapped
  mwd_ram #(.DATA_W(ACC_W), .ADDR_W(HIST_AW)) u_acc_hist (
    .clk     (clk),
    .wr_en   (state == ST_DIFF),
    .wr_addr (hp),
    .wr_data (acc),
    .rd_en   (accept),
    .rd_addr (acc_rd_addr),
    .rd_data (acc_rd_data)
  );

  mwd_ram #(.DATA_W(RES_W), .ADDR_W(AVG_AW)) u_dif_hist (
    .clk     (clk),
    .wr_en   (state == ST_SUM),
    .wr_addr (ap),
    .wr_data (diff_q),
    .rd_en   (accept),
    .rd_addr (dif_rd_addr),
    .rd_data (dif_rd_data)
  );

  // accumulator update: (x - prev) << 16 plus floor(c * prev / 2^16)
  logic signed [SAMPLE_W:0] delta;
  logic signed [32:0]       term;
  assign delta = {sample_q[SAMPLE_W-1], sample_q} - {prev[SAMPLE_W-1], prev};
  assign term  = prod[48:16];
  assign acc_next = acc + {{15{delta[SAMPLE_W]}}, delta, {FRAC_W{1'b0}}}
                        + {{15{term[32]}}, term};

  // window difference, wraps at 48 bits, integer part saturated
  logic [ACC_W-1:0] acc_old;
  logic [ACC_W-1:0] acc_delta;
  assign acc_old   = acc_old_ok ? acc_rd_data : '0;
  assign acc_delta = acc - acc_old;

  // running sum update
  logic signed [RES_W-1:0] dif_old;
  assign dif_old  = dif_old_ok ? $signed(dif_rd_data) : '0;
  assign sum_next = sum + {{(SUM_W-RES_W){diff_q[RES_W-1]}}, diff_q}
                        - {{(SUM_W-RES_W){dif_old[RES_W-1]}}, dif_old};

  // reciprocal scaling: recombine halves, floor by taking the top bits
  logic signed [66:0] scaled_full;
  res_t               avg_res;
  assign scaled_full = ({{16{p_hi[50]}}, p_hi} <<< 16) + {{16{p_lo[50]}}, p_lo};
  assign avg_res     = sat_res(scaled_full[66:32]);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_ACC;
      ST_ACC:  state_next = ST_DIFF;
      ST_DIFF: state_next = ST_SUM;
      ST_SUM:  state_next = ST_MULR;
      ST_MULR: state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      prev       <= '0;
      acc        <= '0;
      hp         <= '0;
      hp_wrapped <= 1'b0;
      ap         <= '0;
      ap_wrapped <= 1'b0;
      sum        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ACC) begin
        acc  <= acc_next;
        prev <= sample_q;
      end
      if (state == ST_DIFF) begin
        hp <= hp + HIST_AW'(1);
        if (hp == '1) hp_wrapped <= 1'b1;
      end
      if (state == ST_SUM) begin
        sum <= sum_next;
        ap  <= ap + AVG_AW'(1);
        if (ap == '1) ap_wrapped <= 1'b1;
      end
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  logic [DEC_W-1:0] out_dec;
  res_t             out_dif;
  res_t             out_avg;

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q   <= $signed(s_tdata[SAMPLE_W-1:0]);
      prod       <= $signed({1'b0, decay_coef}) * prev;
      acc_old_ok <= hp_wrapped || (acc_rd_addr < hp);
      dif_old_ok <= ap_wrapped || (dif_rd_addr < ap);
    end
    if (state == ST_DIFF) begin
      diff_q <= sat_res({{3{acc_delta[ACC_W-1]}}, acc_delta[ACC_W-1:FRAC_W]});
    end
    if (state == ST_MULR) begin
      p_lo <= sum * $signed({1'b0, avg_recip[15:0]});
      p_hi <= sum * $signed({1'b0, avg_recip[31:16]});
    end
    if (state == ST_OUT && out_free) begin
      out_dec <= acc[ACC_W-1:FRAC_W];
      out_dif <= diff_q;
      out_avg <= avg_res;
    end
  end

  assign m_tdata = {out_avg, out_dif, out_dec};

  `ASSERT_NEXT(a_accept_starts, clk, rst, accept, state == ST_ACC)
  `ASSERT_NEXT(a_result_loaded, clk, rst, (state == ST_OUT) && out_free, m_tvalid)
  `ASSERT_NEXT(a_hist_ptr_step, clk, rst, state == ST_DIFF, hp == $past(hp) + HIST_AW'(1))
  `ASSERT_IMPL(a_busy_blocks_in, clk, rst, state != ST_IDLE, !accept)

endmodule
